[design/bnc_pkg.sv]
// Shared types, register codes and the neighbour count function of the neighbour counter.
`default_nettype none
package bnc_pkg;

	localparam logic REG_FRAME_ROWS = 1'b0;
	localparam logic REG_FRAME_COLS = 1'b1;

	typedef struct packed {
		logic ge2;
		logic up;
		logic cur;
		logic left;
		logic here;
	} item_flags_t;

	// Window bit wc*3+wr holds row wr, column wc; the centre sits at (1,1) or shifts to
	// the bottom row or right column, where the missing row or column lies outside the frame.
	function automatic logic [3:0] count_around(input logic [8:0] win, input logic row_low,
		input logic col_right);
		logic [3:0] sum;
		int cr;
		int cc;
		sum = '0;
		cr = row_low ? 2 : 1;
		cc = col_right ? 2 : 1;
		for (int wc = 0; wc < 3; wc++) begin
			for (int wr = 0; wr < 3; wr++) begin
				if (wr >= cr - 1 && wc >= cc - 1 && !(wr == cr && wc == cc)) begin
					sum = sum + 4'(win[wc * 3 + wr]);
				end
			end
		end
		return sum;
	endfunction

endpackage
`default_nettype wire

[design/binary_neighbour_count_3x3.sv]
// Top level of the streaming binary 3x3 neighbour counter.
`default_nettype none
// Samples of a frame enter in raster order and are binarized by sign (negative gives zero);
// each result reports how many of a pixel's eight neighbours are one, counting pixels outside
// the frame as zero. A result appears once its last neighbour has arrived, normally for the
// pixel one row up and one column left, with extra results at the last column and in the last
// row (up to four on the final pixel, the last of them marked with frame_end). One sample is
// accepted per clock cycle while results are taken and each sample yields at most one result;
// for more, the input holds while the result register emits them one per cycle. A sample passes
// the line store read, window update and result register. Writing frame_rows or frame_cols
// restarts the frame; the user must write them only while no results are outstanding, which the
// block does not enforce. The line stores have no reset and need no clearing pass.
module binary_neighbour_count_3x3 #(
	parameter int MAX_DIM = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        sample_valid,
	output logic             sample_ready,
	input  wire logic [15:0] sample,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic      [6:0]  out_row,
	output logic      [6:0]  out_col,
	output logic      [3:0]  neighbour_count,
	output logic             frame_end
);

	localparam int PW = $clog2(MAX_DIM);

	function automatic logic [PW-1:0] dim_last(input logic [7:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0) begin
			w = 32'd1;
		end else if (w > 32'(MAX_DIM)) begin
			w = 32'(MAX_DIM);
		end
		w = w - 32'd1;
		return w[PW-1:0];
	endfunction

	logic [7:0]  frame_rows_q;
	logic [7:0]  frame_cols_q;
	logic        cfg_wr;
	logic [PW-1:0] last_row;
	logic [PW-1:0] last_col;
	logic [PW-1:0] row_q;
	logic [PW-1:0] col_q;
	logic        in_acc;
	bnc_pkg::item_flags_t in_flags;

	logic        valid_s1;
	bnc_pkg::item_flags_t flags_s1;
	logic        bit_s1;
	logic [PW-1:0] row_s1;
	logic [PW-1:0] col_s1;
	logic        older_rd;
	logic        newer_rd;

	logic [8:0]  win_s2;
	logic [3:0]  pend_s2;
	logic        last_s2;
	logic [PW-1:0] row_s2;
	logic [PW-1:0] col_s2;

	logic        emit;
	logic [3:0]  pick;
	logic [3:0]  pend_next;
	logic        s2_free;
	logic        s2_load;
	logic [2:0]  new_col;
	logic        sel_row;
	logic        sel_col;
	logic [PW-1:0] res_row;
	logic [PW-1:0] res_col;
	logic [31:0] res_row_w;
	logic [31:0] res_col_w;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign last_row = dim_last(frame_rows_q);
	assign last_col = dim_last(frame_cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= 8'd1;
			frame_cols_q <= 8'd1;
		end else if (cfg_wr) begin
			case (paddr[2])
				bnc_pkg::REG_FRAME_ROWS: frame_rows_q <= pwdata[7:0];
				bnc_pkg::REG_FRAME_COLS: frame_cols_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bnc_pkg::REG_FRAME_ROWS: prdata = {24'd0, frame_rows_q};
			bnc_pkg::REG_FRAME_COLS: prdata = {24'd0, frame_cols_q};
			default: prdata = '0;
		endcase
	end

	assign in_acc = sample_valid && sample_ready;

	always_comb begin
		in_flags.ge2  = row_q >= PW'(2);
		in_flags.up   = row_q != '0;
		in_flags.cur  = row_q == last_row;
		in_flags.left = col_q != '0;
		in_flags.here = col_q == last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (in_flags.here) begin
				col_q <= '0;
				row_q <= in_flags.cur ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	bnc_line_buf #(
		.DEPTH(MAX_DIM),
		.AW(PW)
	) u_line_buf (
		.clk(clk),
		.en(in_acc),
		.addr(col_q),
		.bit_in(~sample[15]),
		.older_rd(older_rd),
		.newer_rd(newer_rd)
	);

	// Result selection: pending bits in raster order (row above then current row,
	// column to the left then current column).
	assign emit = (pend_s2 != '0) && (!result_valid || result_ready);
	assign pick = pend_s2 & (~pend_s2 + 4'd1);
	assign pend_next = emit ? (pend_s2 & ~pick) : pend_s2;
	assign s2_free = (pend_s2 == '0) || (emit && pend_next == '0);
	assign s2_load = valid_s1 && s2_free;
	assign sample_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s2_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_s1 <= in_flags;
			bit_s1 <= ~sample[15];
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	assign new_col = {bit_s1, flags_s1.up & newer_rd, flags_s1.ge2 & older_rd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
			win_s2 <= '0;
		end else if (s2_load) begin
			pend_s2 <= {flags_s1.cur & flags_s1.here, flags_s1.cur & flags_s1.left,
				flags_s1.up & flags_s1.here, flags_s1.up & flags_s1.left};
			win_s2 <= flags_s1.left ? {new_col, win_s2[8:3]} : {new_col, 6'd0};
		end else begin
			pend_s2 <= pend_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			last_s2 <= flags_s1.cur & flags_s1.here;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	assign sel_row = pick[2] | pick[3];
	assign sel_col = pick[1] | pick[3];
	assign res_row = sel_row ? row_s2 : row_s2 - PW'(1);
	assign res_col = sel_col ? col_s2 : col_s2 - PW'(1);
	assign res_row_w = 32'(res_row);
	assign res_col_w = 32'(res_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row <= res_row_w[6:0];
			out_col <= res_col_w[6:0];
			neighbour_count <= bnc_pkg::count_around(win_s2, sel_row, sel_col);
			frame_end <= last_s2 && (pend_next == '0);
		end
	end

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> valid_s1)
		else $error("Input stalled with an empty first stage.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> neighbour_count <= 4'd8)
		else $error("Neighbour count above eight.");

	a_upper_row_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s2[0] || pend_s2[1]) |-> row_s2 != '0)
		else $error("Result pending for a row above row zero.");

	a_left_col_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s2[0] || pend_s2[2]) |-> col_s2 != '0)
		else $error("Result pending for a column left of column zero.");

endmodule
`default_nettype wire

[design/bnc_line_buf.sv]
// Two one-bit line stores holding the binarized previous two rows.
`default_nettype none
module bnc_line_buf #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] addr,
	input  wire logic          bit_in,
	output logic               older_rd,
	output logic               newer_rd
);

	logic older_mem [DEPTH];
	logic newer_mem [DEPTH];

	// Read and shift happen at the same edge, so the read sees the values before the write.
	always_ff @(posedge clk) begin
		if (en) begin
			older_rd <= older_mem[addr];
			newer_rd <= newer_mem[addr];
			older_mem[addr] <= newer_mem[addr];
			newer_mem[addr] <= bit_in;
		end
	end

endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the streaming binary 3x3 neighbour counter.
`timescale 1ns / 1ps
module tb;

	localparam int MAX_DIM = 128;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_SAMPLES = 410;

	typedef struct packed {
		logic [6:0] row;
		logic [6:0] col;
		logic [3:0] ones;
		logic       last;
	} pixel_count_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	logic [15:0] sample = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [6:0]  out_row;
	logic [6:0]  out_col;
	logic [3:0]  neighbour_count;
	logic        frame_end;

	binary_neighbour_count_3x3 #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_row(out_row),
		.out_col(out_col),
		.neighbour_count(neighbour_count),
		.frame_end(frame_end)
	);

	always #5 clk = ~clk;

	logic [7:0]   cfg_rows = 8'd1;
	logic [7:0]   cfg_cols = 8'd1;
	logic         older_line [MAX_DIM] = '{default: 1'b0};
	logic         newer_line [MAX_DIM] = '{default: 1'b0};
	int           cur_row = 0;
	int           cur_col = 0;
	logic [8:0]   window = '0;

	logic [15:0]  samples_to_send [$];
	pixel_count_t pending_counts [$];
	pixel_count_t front_count;
	int           pct_choices [5] = '{0, 15, 50, 85, 100};
	bit           quiet = 1'b0;
	int           send_gap = 0;
	int           recv_hold = 0;
	int           cycles = 0;
	int           mismatches = 0;
	int           results_seen = 0;
	int           samples_taken = 0;
	int           phases = 0;

	function automatic int eff_dim(input logic [7:0] v);
		if (v == 8'd0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [3:0] ones_around(input logic [8:0] win, input int cr, input int cc);
		logic [3:0] sum;
		int r;
		int c;
		sum = '0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				r = cr + dr;
				c = cc + dc;
				if (!(dr == 0 && dc == 0) && r >= 0 && r < 3 && c >= 0 && c < 3) begin
					sum = sum + 4'(win[c * 3 + r]);
				end
			end
		end
		return sum;
	endfunction

	task automatic predict_pixel_counts(input logic [15:0] s);
		int rows;
		int cols;
		int r;
		int c;
		int nr;
		int nc;
		logic px;
		logic top;
		logic mid;
		int out_r [2];
		int cen_r [2];
		int out_c [2];
		int cen_c [2];
		pixel_count_t res;
		rows = eff_dim(cfg_rows);
		cols = eff_dim(cfg_cols);
		r = (cur_row >= rows) ? 0 : cur_row;
		c = (cur_col >= cols) ? 0 : cur_col;
		px = ~s[15];
		top = (r >= 2) ? older_line[c] : 1'b0;
		mid = (r >= 1) ? newer_line[c] : 1'b0;
		older_line[c] = newer_line[c];
		newer_line[c] = px;
		window = (c == 0) ? 9'd0 : (window >> 3);
		window[8:6] = {px, mid, top};
		nr = 0;
		nc = 0;
		if (r >= 1) begin
			out_r[nr] = r - 1;
			cen_r[nr] = 1;
			nr++;
		end
		if (r == rows - 1) begin
			out_r[nr] = r;
			cen_r[nr] = 2;
			nr++;
		end
		if (c >= 1) begin
			out_c[nc] = c - 1;
			cen_c[nc] = 1;
			nc++;
		end
		if (c == cols - 1) begin
			out_c[nc] = c;
			cen_c[nc] = 2;
			nc++;
		end
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				res.row = 7'(out_r[i]);
				res.col = 7'(out_c[j]);
				res.ones = ones_around(window, cen_r[i], cen_c[j]);
				res.last = (r == rows - 1) && (c == cols - 1) && (i == nr - 1) && (j == nc - 1);
				pending_counts.push_back(res);
			end
		end
		if (c + 1 < cols) begin
			cur_col = c + 1;
			cur_row = r;
		end else begin
			cur_col = 0;
			cur_row = (r + 1 < rows) ? r + 1 : 0;
		end
	endtask

	function automatic int idle_cycles();
		int k;
		if (quiet) return 0;
		k = $urandom_range(0, 99);
		if (k < 40) return 0;
		if (k < 85) return $urandom_range(1, 3);
		if (k < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [15:0] random_sample(input int pct);
		logic [15:0] s;
		logic one;
		one = ($urandom_range(0, 99) < pct);
		case ($urandom_range(0, 9))
			0: s = one ? 16'h0000 : 16'hFFFF;
			1: s = one ? 16'h7FFF : 16'h8000;
			default: begin
				s = 16'($urandom);
				s[15] = ~one;
			end
		endcase
		return s;
	endfunction

	function automatic logic [7:0] pick_dim();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return 8'd0;
		if (k <= 2) return 8'($urandom_range(7, 16));
		return 8'($urandom_range(1, 6));
	endfunction

	task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 40) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (samples_to_send.size() != 0 || sample_valid || pending_counts.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bnc_pkg::REG_FRAME_ROWS) begin
			cfg_rows = value;
		end else begin
			cfg_cols = value;
		end
		cur_row = 0;
		cur_col = 0;
		window = '0;
	endtask

	task automatic configure(input logic [7:0] rows, input logic [7:0] cols);
		wait_idle();
		write_reg(bnc_pkg::REG_FRAME_ROWS, rows);
		write_reg(bnc_pkg::REG_FRAME_COLS, cols);
		quiet = ($urandom_range(0, 3) == 0);
		phases++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				sample_valid <= 1'b0;
			end else if (samples_to_send.size() != 0) begin
				sample_valid <= 1'b1;
				sample <= samples_to_send.pop_front();
				send_gap = idle_cycles();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) recv_hold = idle_cycles();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (pending_counts.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got row %0d col %0d count %0d end %0b",
						$time, out_row, out_col, neighbour_count, frame_end);
				end else begin
					front_count = pending_counts.pop_front();
					check_field("out_row", front_count.row, out_row);
					check_field("out_col", front_count.col, out_col);
					check_field("neighbour_count", 7'(front_count.ones), 7'(neighbour_count));
					check_field("frame_end", 7'(front_count.last), 7'(frame_end));
				end
			end
			if (sample_valid && sample_ready) begin
				samples_taken++;
				predict_pixel_counts(sample);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycles,
				pending_counts.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] directed [25];
		int queued;
		int n;
		int pct;
		directed = '{16'h8000, 16'h7FFF,
			16'h0000, 16'h0001, 16'h7FFF, 16'h1234, 16'h0000, 16'h4000, 16'h7FFE, 16'h0F0F,
			16'h3C3C, 16'hFFFF, 16'h8000, 16'h8001, 16'hFFFE,
			16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h00FF, 16'hFF00,
			16'h0001, 16'hC000};
		queued = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		configure(8'd0, 8'd0);
		for (int i = 0; i < 2; i++) samples_to_send.push_back(directed[i]);
		configure(8'd3, 8'd3);
		for (int i = 2; i < 15; i++) samples_to_send.push_back(directed[i]);
		configure(8'd2, 8'd5);
		for (int i = 15; i < 25; i++) samples_to_send.push_back(directed[i]);

		configure(8'd255, 8'd1);
		repeat (128) samples_to_send.push_back(random_sample(50));
		configure(8'd1, 8'd128);
		repeat (128) samples_to_send.push_back(random_sample(70));
		queued = 25 + 256;

		while (queued < RANDOM_SAMPLES) begin
			configure(pick_dim(), pick_dim());
			pct = pct_choices[$urandom_range(0, 4)];
			n = eff_dim(cfg_rows) * eff_dim(cfg_cols);
			if (n <= 40) n = n * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
			if (n > RANDOM_SAMPLES - queued) n = RANDOM_SAMPLES - queued;
			repeat (n) samples_to_send.push_back(random_sample(pct));
			queued += n;
		end

		wait_idle();
		$display("Ran %0d samples through %0d frame settings and checked %0d neighbour counts.",
			samples_taken, phases, results_seen);
		if (mismatches == 0 && pending_counts.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
design/bnc_pkg.sv
design/bnc_line_buf.sv
design/binary_neighbour_count_3x3.sv
dv/tb.sv
